// ===== rtl/core/ltc_pkg.sv =====
// Shared types and constants for the LFU tag cache.
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int TAG_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int RMCNT_W  = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;
    localparam int M_USED_W = 1 + SLOT_W + 1 + TAG_W + RMCNT_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [CNT_W-1:0]   CNT_TOP   = '1;
    localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
    localparam logic [RMCNT_W-1:0] RMCNT_TOP = '1;

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [TAG_W-1:0] state_tag;
        logic [TAG_W-1:0] node;
    } entry_t;

    typedef struct packed {
        logic [RMCNT_W-1:0] removed_count;
        logic [TAG_W-1:0]   evicted_node;
        logic               evicted;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
    } result_t;

endpackage

// ===== rtl/core/lfu_tag_cache_lookup_replace.sv =====
// LFU fully associative tag cache: lookup with fill/replace, and remove by node.
// Each item is scanned over all slots, then the compare stage drains and the result
// is registered once the output is free; the input is not ready until then.
// The slot scan does one slot memory read and one tag/counter compare per cycle.
// The result register holds its transfer while the next item is taken.
// Reset clears all valid bits and control state; slot tags and counters are not cleared.
`timescale 1ns / 1ps

module lfu_tag_cache_lookup_replace #(
    parameter int ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // node_id [31:0], state_tag [63:32]
    input  logic [ltc_pkg::S_DATA_W-1:0]   s_tdata,
    // command [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit [0], slot [4:1], evicted [5], evicted_node [37:6],
    // removed_count [42:38], zero [47:43]
    output logic [ltc_pkg::M_DATA_W-1:0]   m_tdata
);

    import ltc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;

    entry_t slot_mem [ENTRIES];
    entry_t rd_data_reg;

    logic [2:0]         state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_en_reg, cmp_en_next;

    logic               cmd_reg, cmd_next;
    logic [TAG_W-1:0]   node_reg, node_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;

    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   min_cnt_reg, min_cnt_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [TAG_W-1:0]   min_node_reg, min_node_next;
    logic [RMCNT_W-1:0] rm_count_reg, rm_count_next;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               out_free;
    logic               node_eq;
    logic               state_eq;
    logic               cmp_slot_valid;
    logic               cnt_less;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;
    logic [IDX_W+SLOT_W-1:0] slot_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - M_USED_W){1'b0}}, out_reg};
    assign out_free = !out_valid_reg || m_tready;

    assign node_eq        = (rd_data_reg.node == node_reg);
    assign state_eq       = (rd_data_reg.state_tag == tag_reg);
    assign cmp_slot_valid = valid_reg[cmp_idx_reg];
    assign cnt_less       = (rd_data_reg.hits < min_cnt_reg);
    assign slot_wide      = {{SLOT_W{1'b0}}, wr_idx};

    always_comb
    begin
        if (hit_found_reg)
        begin
            wr_idx = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            wr_idx = free_idx_reg;
        end
        else
        begin
            wr_idx = min_idx_reg;
        end
        wr_data.node      = node_reg;
        wr_data.state_tag = tag_reg;
        if (hit_found_reg)
        begin
            wr_data.hits = (hit_cnt_reg == CNT_TOP) ? hit_cnt_reg : hit_cnt_reg + CNT_ONE;
        end
        else
        begin
            wr_data.hits = CNT_ONE;
        end
        mem_we = (state_reg == ST_UPDATE) && out_free && (cmd_reg == CMD_LOOKUP);
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        addr_next       = addr_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_en_next     = 1'b0;
        cmd_next        = cmd_reg;
        node_next       = node_reg;
        tag_next        = tag_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        min_cnt_next    = min_cnt_reg;
        min_idx_next    = min_idx_reg;
        min_node_next   = min_node_reg;
        rm_count_next   = rm_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;

        // compare stage, one slot per cycle
        if (cmp_en_reg && cmp_slot_valid)
        begin
            if (cmd_reg == CMD_REMOVE)
            begin
                if (node_eq)
                begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    if (rm_count_reg != RMCNT_TOP)
                    begin
                        rm_count_next = rm_count_reg + RMCNT_W'(1);
                    end
                end
            end
            else
            begin
                if (node_eq && state_eq && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_cnt_next   = rd_data_reg.hits;
                end
                if ((cmp_idx_reg == IDX_ZERO) || cnt_less)
                begin
                    min_cnt_next  = rd_data_reg.hits;
                    min_idx_next  = cmp_idx_reg;
                    min_node_next = rd_data_reg.node;
                end
            end
        end
        if (cmp_en_reg && !cmp_slot_valid && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = s_tuser;
                    node_next       = s_tdata[TAG_W-1:0];
                    tag_next        = s_tdata[2*TAG_W-1:TAG_W];
                    addr_next       = IDX_ZERO;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    rm_count_next   = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_en_next  = 1'b1;
                cmp_idx_next = addr_reg;
                if (addr_reg == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.hit          = 1'b0;
                    out_next.slot         = '0;
                    out_next.evicted      = 1'b0;
                    out_next.evicted_node = '0;
                    out_next.removed_count = '0;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        out_next.removed_count = rm_count_reg;
                    end
                    else
                    begin
                        valid_next[wr_idx] = 1'b1;
                        out_next.slot      = slot_wide[SLOT_W-1:0];
                        out_next.hit       = hit_found_reg;
                        if (!hit_found_reg && !free_found_reg)
                        begin
                            out_next.evicted      = 1'b1;
                            out_next.evicted_node = min_node_reg;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= slot_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            cmp_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cmp_en_reg     <= cmp_en_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmd_reg        <= cmd_next;
        node_reg       <= node_next;
        tag_reg        <= tag_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        min_cnt_reg    <= min_cnt_next;
        min_idx_reg    <= min_idx_next;
        min_node_reg   <= min_node_next;
        rm_count_reg   <= rm_count_next;
        out_reg        <= out_next;
    end

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN))
        else $error("scan did not start after input transfer");

    a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_en_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("compare stage active outside scan");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.hit && out_reg.evicted))
        else $error("result reports both hit and eviction");

    a_remove_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && out_free && cmd_reg == CMD_REMOVE)
            |=> (out_reg.hit == 1'b0 && out_reg.evicted == 1'b0))
        else $error("remove reported a hit or eviction");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LFU tag cache: lookup, fill, replace and remove.
`timescale 1ns / 1ps

module testbench;
    import ltc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int NODE_POOL   = 20;
    localparam int STATE_POOL  = 3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = CMD_LOOKUP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // mirror of the cache contents
    logic             tag_valid [SLOTS];
    logic [TAG_W-1:0] tag_node  [SLOTS];
    logic [TAG_W-1:0] tag_state [SLOTS];
    logic [CNT_W-1:0] tag_hits  [SLOTS];

    result_t          pending_results [$];
    result_t          want;
    result_t          got;
    logic [TAG_W-1:0] node_pool  [NODE_POOL];
    logic [TAG_W-1:0] state_pool [STATE_POOL];

    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   hold_left = 0;
    int   gap_left = 0;
    logic idle_en = 1'b1;

    lfu_tag_cache_lookup_replace #(.ENTRIES(SLOTS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t apply_command(input logic cmd, input logic [TAG_W-1:0] node,
                                              input logic [TAG_W-1:0] tag);
        result_t r;
        int      found;
        int      victim;
        int      cnt;
        r = '0;
        found = -1;
        victim = -1;
        cnt = 0;
        if (cmd == CMD_REMOVE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tag_valid[i] && tag_node[i] == node)
                begin
                    tag_valid[i] = 1'b0;
                    cnt++;
                end
            end
            r.removed_count = (cnt > 31) ? RMCNT_TOP : RMCNT_W'(cnt);
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && tag_valid[i] && tag_node[i] == node && tag_state[i] == tag)
                    found = i;
            if (found >= 0)
            begin
                if (tag_hits[found] != CNT_TOP)
                    tag_hits[found] = tag_hits[found] + CNT_ONE;
                r.hit = 1'b1;
                r.slot = SLOT_W'(found);
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (victim < 0 && !tag_valid[i])
                        victim = i;
                if (victim < 0)
                begin
                    // least used, lowest index on ties
                    victim = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (tag_hits[i] < tag_hits[victim])
                            victim = i;
                    r.evicted = 1'b1;
                    r.evicted_node = tag_node[victim];
                end
                tag_valid[victim] = 1'b1;
                tag_node[victim] = node;
                tag_state[victim] = tag;
                tag_hits[victim] = CNT_ONE;
                r.slot = SLOT_W'(victim);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, got %h expected %h", $realtime, what, seen, wanted);
    endtask

    task automatic send_item(input logic cmd, input logic [TAG_W-1:0] node,
                             input logic [TAG_W-1:0] tag);
        if (idle_en && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {tag, node};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_command(cmd, node, tag));
    endtask

    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_fill_and_hit;
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // node not present
        send_item(CMD_REMOVE, 32'h1234_5678, 32'hFFFF_FFFF);
        send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        // freed slots are refilled lowest first
        send_item(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(CMD_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int i = 4; i < SLOTS; i++)
            send_item(CMD_LOOKUP, 32'h0000_0100 + i, $urandom());
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // full: replacement on equal counters
        send_item(CMD_LOOKUP, 32'hDEAD_0001, 32'h0000_0001);
        send_item(CMD_LOOKUP, 32'hDEAD_0002, 32'h0000_0002);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic pool_item;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_item(CMD_LOOKUP, node_pool[$urandom_range(0, $urandom_range(0, NODE_POOL - 1))],
                      state_pool[$urandom_range(0, STATE_POOL - 1)]);
        else if (pick < 82)
            send_item(CMD_REMOVE, node_pool[$urandom_range(0, NODE_POOL - 1)], $urandom());
        else if (pick < 94)
            send_item(CMD_LOOKUP, $urandom(), $urandom());
        else
            send_item(CMD_REMOVE, $urandom(), $urandom());
    endtask

    task automatic test_random_pool;
        node_pool[0] = 32'h0000_0000;
        node_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < NODE_POOL; i++)
            node_pool[i] = $urandom();
        state_pool[0] = 32'h0000_0000;
        state_pool[1] = 32'hFFFF_FFFF;
        state_pool[2] = $urandom();
        for (int n = 0; n < 600; n++)
        begin
            // output held off while input keeps coming
            if (n == 300)
                hold_requests <= hold_requests + 1;
            pool_item();
        end
    endtask

    task automatic test_sender_pause;
        for (int n = 0; n < 15; n++)
            pool_item();
        wait_results_drained();
    endtask

    task automatic test_remove_many;
        logic [TAG_W-1:0] node;
        logic [TAG_W-1:0] few_nodes [3];
        int               slot_idx;
        slot_idx = 0;
        while (slot_idx < SLOTS)
        begin
            if (tag_valid[slot_idx])
                send_item(CMD_REMOVE, tag_node[slot_idx], $urandom());
            else
                slot_idx++;
        end
        node = $urandom();
        for (int i = 0; i < SLOTS; i++)
            send_item(CMD_LOOKUP, node, {8'($urandom_range(255)), 8'(i), 16'(i)});
        send_item(CMD_REMOVE, node, $urandom());
        for (int i = 0; i < 3; i++)
            few_nodes[i] = $urandom();
        for (int n = 0; n < 150; n++)
        begin
            if ($urandom_range(3) == 0)
                send_item(CMD_REMOVE, few_nodes[$urandom_range(0, 2)], $urandom());
            else
                send_item(CMD_LOOKUP, few_nodes[$urandom_range(0, 2)], 32'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_steady_stream;
        idle_en <= 1'b0;
        for (int n = 0; n < 150; n++)
            pool_item();
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_valid[i] = 1'b0;
            tag_node[i] = '0;
            tag_state[i] = '0;
            tag_hits[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_and_hit();
        test_random_pool();
        test_sender_pause();
        test_remove_many();
        test_steady_stream();
        wait_results_drained();
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (gap_left != 0)
        begin
            gap_left <= gap_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(4) == 0)
        begin
            gap_left <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer", 64'(m_tdata), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                got = result_t'(m_tdata[M_USED_W-1:0]);
                if (got.hit != want.hit)
                    report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                if (got.slot != want.slot)
                    report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                if (got.evicted != want.evicted)
                    report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
                if (got.evicted_node != want.evicted_node)
                    report_mismatch("evicted_node", 64'(got.evicted_node),
                                    64'(want.evicted_node));
                if (got.removed_count != want.removed_count)
                    report_mismatch("removed_count", 64'(got.removed_count),
                                    64'(want.removed_count));
                if (m_tdata[M_DATA_W-1:M_USED_W] != '0)
                    report_mismatch("padding", 64'(m_tdata[M_DATA_W-1:M_USED_W]), 64'd0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/ltc_pkg.sv
rtl/core/lfu_tag_cache_lookup_replace.sv
tb/testbench.sv
